// ----- src/assert_macros.svh -----
// assertion macros used by motor_pd_current_control_ff.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define MPD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("mpdcc assertion failed");

// clocked assertion that is also checked during reset
`define MPD_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mpdcc assertion failed");

`endif

// ----- src/mpdcc_pkg.sv -----
// types and constants of the pd current controller
package mpdcc_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_POSITION_GAIN        = 3'd0,
        REG_DAMPING_GAIN         = 3'd1,
        REG_FEEDFORWARD_CURRENT  = 3'd2,
        REG_RUNNING_RATIO        = 3'd3,
        REG_BREAKAWAY_ENTER_RPM  = 3'd4,
        REG_BREAKAWAY_EXIT_RPM   = 3'd5,
        REG_ACTIVE_RPM_THRESHOLD = 3'd6,
        REG_POSITION_ERROR_LIMIT = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] position_gain;
        logic [15:0] damping_gain;
        logic [14:0] feedforward_current;
        logic [8:0]  running_ratio;
        logic [14:0] breakaway_enter_rpm;
        logic [14:0] breakaway_exit_rpm;
        logic [14:0] active_rpm_threshold;
        logic [19:0] position_error_limit;
    } cfg_t;

    localparam logic [8:0] RUNNING_RATIO_RST = 9'd256;

    typedef enum logic [1:0] {
        PATH_OFFLINE    = 2'd0,
        PATH_BRAKE_DONE = 2'd1,
        PATH_BRAKING    = 2'd2,
        PATH_TRACKING   = 2'd3
    } path_t;

    typedef enum logic [1:0] {
        SIGN_ZERO = 2'b00,
        SIGN_POS  = 2'b01,
        SIGN_NEG  = 2'b11
    } tsign_t;

    // setpoint advance per rpm and microsecond of period: 384 * 2^16 / 10^6, reduced by 64
    localparam longint unsigned RATE_NUM = 64'd384 * 64'd65536 / 64'd64;
    localparam longint unsigned RATE_DEN = 64'd1000000 / 64'd64;

    // rounding divide floor((2x + den) / (2 den)) done as a reciprocal multiply
    localparam longint unsigned RND_DIV   = 2 * RATE_DEN;
    localparam int              RND_SHIFT = 45;
    localparam int              RND_MUL_W = 31;
    localparam longint unsigned RND_MUL   = ((64'd1 << RND_SHIFT) + RND_DIV - 64'd1) / RND_DIV;

    localparam int SP_W   = 48;
    localparam int FRAC_W = 16;

endpackage

// ----- src/motor_pd_current_control_ff.sv -----
// path: input register, products, rounding, loop state, gain product, then the output register (sum, scale, saturate)
// throughput: one item per cycle unless m_tready stalls the output; setpoint and breakaway state update in stage 4
// every stage holds its item only while the stage after it is full, so bubbles close up
// reset (aresetn low, synchronous): pipeline empty, setpoint 0, breakaway on, target sign zero
// reset registers: all gains and limits 0, running ratio 256
`include "assert_macros.svh"

module motor_pd_current_control_ff #(
    parameter int OUTPUT_LIMIT      = 16384,
    parameter int BRAKE_LIMIT       = 8192,
    parameter int BRAKE_DONE_RPM    = 16,
    parameter int CONTROL_PERIOD_US = 1000
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // target_rpm[15:0], measured_rpm[31:16], measured_position[63:32],
    // speed_link_online[64], position_link_online[65], zero fill[71:66]
    input  logic [71:0]                      s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // drive_current[15:0], position_error_used[36:16], zero fill[39:37]
    output logic [39:0]                      m_tdata,
    // control_path[1:0]
    output logic [1:0]                       m_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mpdcc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mpdcc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mpdcc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready
);

    localparam longint unsigned STEP_NUM = mpdcc_pkg::RATE_NUM * longint'(CONTROL_PERIOD_US);
    localparam logic [31:0] STEP_Q = 32'(STEP_NUM / mpdcc_pkg::RATE_DEN);
    localparam logic [13:0] STEP_R = 14'(STEP_NUM % mpdcc_pkg::RATE_DEN);
    localparam logic [mpdcc_pkg::RND_MUL_W-1:0] RND_K = mpdcc_pkg::RND_MUL_W'(mpdcc_pkg::RND_MUL);
    localparam logic [15:0] DONE_RPM = 16'(BRAKE_DONE_RPM);
    localparam logic signed [39:0] OUT_LIM = 40'(OUTPUT_LIMIT);
    localparam logic signed [39:0] BRK_LIM = 40'(BRAKE_LIMIT);
    localparam logic signed [15:0] BRK_LIM16 = 16'(BRAKE_LIMIT);

    mpdcc_pkg::cfg_t cfg;

    mpdcc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------- stage handshake ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg, m_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6     = !m_valid_reg || m_tready;
    assign rdy5     = !s5_valid_reg || rdy6;
    assign rdy4     = !s4_valid_reg || rdy5;
    assign rdy3     = !s3_valid_reg || rdy4;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (rdy1) begin
                s1_valid_reg <= s_tvalid;
            end
            if (rdy2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4) begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (rdy5) begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (rdy6) begin
                m_valid_reg <= s5_valid_reg;
            end
        end
    end

    // ---------------- stage 1: input register ----------------
    logic signed [15:0] s1_target_reg, s1_meas_reg;
    logic signed [31:0] s1_pos_reg;
    logic               s1_sok_reg, s1_pok_reg;

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            s1_target_reg <= s_tdata[15:0];
            s1_meas_reg   <= s_tdata[31:16];
            s1_pos_reg    <= s_tdata[63:32];
            s1_sok_reg    <= s_tdata[64];
            s1_pok_reg    <= s_tdata[65];
        end
    end

    // ---------------- stage 1 -> 2: path select, step and damping products ----------------
    logic [15:0]        abs_t, abs_m;
    mpdcc_pkg::path_t   path1;
    logic signed [16:0] drv_op;
    logic signed [33:0] dprod1;
    logic [47:0]        mag_hi1;
    logic [29:0]        xfrac1;

    assign abs_t = s1_target_reg[15] ? (~s1_target_reg + 16'd1) : s1_target_reg;
    assign abs_m = s1_meas_reg[15] ? (~s1_meas_reg + 16'd1) : s1_meas_reg;

    always_comb begin
        priority if (!s1_sok_reg) begin
            path1 = mpdcc_pkg::PATH_OFFLINE;
        end else if (abs_t <= 16'(cfg.active_rpm_threshold)) begin
            path1 = (abs_m <= DONE_RPM) ? mpdcc_pkg::PATH_BRAKE_DONE : mpdcc_pkg::PATH_BRAKING;
        end else begin
            path1 = mpdcc_pkg::PATH_TRACKING;
        end
    end

    // braking damps toward zero speed, tracking damps the speed error
    assign drv_op = (path1 == mpdcc_pkg::PATH_BRAKING)
                  ? (17'sd0 - {s1_meas_reg[15], s1_meas_reg})
                  : ({s1_target_reg[15], s1_target_reg} - {s1_meas_reg[15], s1_meas_reg});
    assign dprod1  = $signed({1'b0, cfg.damping_gain}) * drv_op;
    assign mag_hi1 = 48'(abs_t) * 48'(STEP_Q);
    assign xfrac1  = 30'(abs_t) * 30'(STEP_R);

    mpdcc_pkg::path_t   s2_path_reg;
    logic               s2_pok_reg, s2_tneg_reg, s2_tpos_reg;
    logic signed [31:0] s2_pos_reg;
    logic [15:0]        s2_abs_m_reg;
    logic signed [33:0] s2_dprod_reg;
    logic [47:0]        s2_mag_hi_reg;
    logic [29:0]        s2_xfrac_reg;

    always_ff @(posedge aclk) begin
        if (rdy2 && s1_valid_reg) begin
            s2_path_reg   <= path1;
            s2_pok_reg    <= s1_pok_reg;
            s2_tneg_reg   <= s1_target_reg[15];
            s2_tpos_reg   <= (s1_target_reg > 16'sd0);
            s2_pos_reg    <= s1_pos_reg;
            s2_abs_m_reg  <= abs_m;
            s2_dprod_reg  <= dprod1;
            s2_mag_hi_reg <= mag_hi1;
            s2_xfrac_reg  <= xfrac1;
        end
    end

    // ---------------- stage 2 -> 3: round the fractional step ----------------
    logic [30:0] rnd_y;
    logic [61:0] rnd_prod;

    assign rnd_y    = {s2_xfrac_reg, 1'b0} + 31'(mpdcc_pkg::RATE_DEN);
    assign rnd_prod = 62'(rnd_y) * 62'(RND_K);

    mpdcc_pkg::path_t   s3_path_reg;
    logic               s3_pok_reg, s3_tneg_reg, s3_tpos_reg;
    logic signed [31:0] s3_pos_reg;
    logic [15:0]        s3_abs_m_reg;
    logic signed [33:0] s3_dprod_reg;
    logic [47:0]        s3_mag_hi_reg;
    logic [15:0]        s3_qfrac_reg;

    always_ff @(posedge aclk) begin
        if (rdy3 && s2_valid_reg) begin
            s3_path_reg   <= s2_path_reg;
            s3_pok_reg    <= s2_pok_reg;
            s3_tneg_reg   <= s2_tneg_reg;
            s3_tpos_reg   <= s2_tpos_reg;
            s3_pos_reg    <= s2_pos_reg;
            s3_abs_m_reg  <= s2_abs_m_reg;
            s3_dprod_reg  <= s2_dprod_reg;
            s3_mag_hi_reg <= s2_mag_hi_reg;
            s3_qfrac_reg  <= rnd_prod[mpdcc_pkg::RND_SHIFT +: 16];
        end
    end

    // ---------------- stage 3 -> 4: loop state ----------------
    logic [mpdcc_pkg::SP_W-1:0] setpoint_reg, setpoint_next;
    logic                       breakaway_reg, breakaway_next;
    mpdcc_pkg::tsign_t          sign_reg, sign_next;
    logic [23:0]                ff_run_reg;

    logic [47:0]        step_mag, step, pos_frac, sp_adv;
    logic signed [47:0] err_raw, err_cl, lim_pos, lim_neg;
    logic [47:0]        err_abs;
    logic [19:0]        err_mag;
    logic signed [20:0] err_calc, err_next;
    mpdcc_pkg::tsign_t  sign_trk;
    logic               bo_calc;
    logic [23:0]        ff_mag;
    logic signed [24:0] ff_next;
    logic               state_go;

    assign state_go = s3_valid_reg && rdy4;
    assign step_mag = s3_mag_hi_reg + 48'(s3_qfrac_reg);
    assign step     = s3_tneg_reg ? (48'd0 - step_mag) : step_mag;
    assign pos_frac = {s3_pos_reg, 16'b0};
    assign sp_adv   = setpoint_reg + step;
    assign err_raw  = $signed(sp_adv - pos_frac);
    assign lim_pos  = $signed({12'b0, cfg.position_error_limit, 16'b0});
    assign lim_neg  = -lim_pos;

    always_comb begin
        priority if (err_raw > lim_pos) begin
            err_cl = lim_pos;
        end else if (err_raw < lim_neg) begin
            err_cl = lim_neg;
        end else begin
            err_cl = err_raw;
        end
    end

    // truncate toward zero to whole 1/64 degree
    assign err_abs  = err_cl[47] ? (48'd0 - err_cl) : err_cl;
    assign err_mag  = err_abs[mpdcc_pkg::FRAC_W +: 20];
    assign err_calc = err_cl[47] ? -$signed({1'b0, err_mag}) : $signed({1'b0, err_mag});

    assign sign_trk = s3_tpos_reg ? mpdcc_pkg::SIGN_POS : mpdcc_pkg::SIGN_NEG;

    // enter test first, then exit, else hold (a reversal re-arms breakaway)
    always_comb begin
        priority if (s3_abs_m_reg <= 16'(cfg.breakaway_enter_rpm)) begin
            bo_calc = 1'b1;
        end else if (s3_abs_m_reg >= 16'(cfg.breakaway_exit_rpm)) begin
            bo_calc = 1'b0;
        end else begin
            bo_calc = breakaway_reg || (sign_trk != sign_reg);
        end
    end

    assign ff_mag  = bo_calc ? {1'b0, cfg.feedforward_current, 8'b0} : ff_run_reg;
    assign ff_next = s3_tpos_reg ? $signed({1'b0, ff_mag}) : -$signed({1'b0, ff_mag});

    always_comb begin
        setpoint_next  = pos_frac;
        breakaway_next = 1'b1;
        sign_next      = mpdcc_pkg::SIGN_ZERO;
        err_next       = '0;
        if (s3_path_reg == mpdcc_pkg::PATH_TRACKING) begin
            breakaway_next = bo_calc;
            sign_next      = sign_trk;
            if (s3_pok_reg) begin
                setpoint_next = pos_frac + err_cl;
                err_next      = err_calc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ff_run_reg <= 24'(cfg.feedforward_current) * 24'(cfg.running_ratio);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg  <= '0;
            breakaway_reg <= 1'b1;
            sign_reg      <= mpdcc_pkg::SIGN_ZERO;
        end else if (state_go) begin
            setpoint_reg  <= setpoint_next;
            breakaway_reg <= breakaway_next;
            sign_reg      <= sign_next;
        end
    end

    mpdcc_pkg::path_t   s4_path_reg;
    logic signed [20:0] s4_err_reg;
    logic signed [24:0] s4_ff_reg;
    logic signed [33:0] s4_dprod_reg;

    always_ff @(posedge aclk) begin
        if (state_go) begin
            s4_path_reg  <= s3_path_reg;
            s4_err_reg   <= err_next;
            s4_ff_reg    <= ff_next;
            s4_dprod_reg <= s3_dprod_reg;
        end
    end

    // ---------------- stage 4 -> 5: position gain product ----------------
    logic signed [37:0] pprod4;

    assign pprod4 = $signed({1'b0, cfg.position_gain}) * s4_err_reg;

    mpdcc_pkg::path_t   s5_path_reg;
    logic signed [20:0] s5_err_reg;
    logic signed [24:0] s5_ff_reg;
    logic signed [33:0] s5_dprod_reg;
    logic signed [37:0] s5_pprod_reg;

    always_ff @(posedge aclk) begin
        if (rdy5 && s4_valid_reg) begin
            s5_path_reg  <= s4_path_reg;
            s5_err_reg   <= s4_err_reg;
            s5_ff_reg    <= s4_ff_reg;
            s5_dprod_reg <= s4_dprod_reg;
            s5_pprod_reg <= pprod4;
        end
    end

    // ---------------- stage 5 -> out: sum, scale, saturate ----------------
    logic signed [39:0] sum_trk, sum_brk, q_trk, q_brk, cur_sel;
    logic signed [15:0] drive_next;

    assign sum_trk = 40'(s5_pprod_reg) + 40'(s5_dprod_reg) + 40'(s5_ff_reg);
    assign sum_brk = 40'(s5_dprod_reg);
    // divide by 256 rounding toward zero
    assign q_trk = (sum_trk + (sum_trk[39] ? 40'sd255 : 40'sd0)) >>> 8;
    assign q_brk = (sum_brk + (sum_brk[39] ? 40'sd255 : 40'sd0)) >>> 8;

    always_comb begin
        unique case (s5_path_reg)
            mpdcc_pkg::PATH_OFFLINE,
            mpdcc_pkg::PATH_BRAKE_DONE: begin
                cur_sel = '0;
            end
            mpdcc_pkg::PATH_BRAKING: begin
                priority if (q_brk > BRK_LIM) begin
                    cur_sel = BRK_LIM;
                end else if (q_brk < -BRK_LIM) begin
                    cur_sel = -BRK_LIM;
                end else begin
                    cur_sel = q_brk;
                end
            end
            mpdcc_pkg::PATH_TRACKING: begin
                priority if (q_trk > OUT_LIM) begin
                    cur_sel = OUT_LIM;
                end else if (q_trk < -OUT_LIM) begin
                    cur_sel = -OUT_LIM;
                end else begin
                    cur_sel = q_trk;
                end
            end
        endcase
    end

    assign drive_next = cur_sel[15:0];

    logic signed [15:0] m_drive_reg;
    logic signed [20:0] m_err_reg;
    mpdcc_pkg::path_t   m_path_reg;

    always_ff @(posedge aclk) begin
        if (rdy6 && s5_valid_reg) begin
            m_drive_reg <= drive_next;
            m_err_reg   <= s5_err_reg;
            m_path_reg  <= s5_path_reg;
        end
    end

    assign m_tdata = {3'b0, m_err_reg, m_drive_reg};
    assign m_tuser = m_path_reg;

    // ---------------- checks ----------------
    `MPD_ASSERT(a_idle_path_zero_current, aclk, aresetn,
        (m_valid_reg && (m_path_reg == mpdcc_pkg::PATH_OFFLINE || m_path_reg == mpdcc_pkg::PATH_BRAKE_DONE)) |-> (m_drive_reg == 16'sd0))
    `MPD_ASSERT(a_brake_bound, aclk, aresetn,
        (m_valid_reg && m_path_reg == mpdcc_pkg::PATH_BRAKING) |-> (m_drive_reg <= BRK_LIM16 && m_drive_reg >= -BRK_LIM16))
    `MPD_ASSERT(a_err_only_tracking, aclk, aresetn,
        (m_valid_reg && m_path_reg != mpdcc_pkg::PATH_TRACKING) |-> (m_err_reg == 21'sd0))
    `MPD_ASSERT_NR(a_setpoint_holds, aclk,
        (aresetn && !state_go) |=> $stable(setpoint_reg))

endmodule

// ----- src/mpdcc_regs.sv -----
// apb configuration register file of the pd current controller
module mpdcc_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mpdcc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [mpdcc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [mpdcc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                 pready,
    output mpdcc_pkg::cfg_t                      cfg
);

    mpdcc_pkg::cfg_t     cfg_reg;
    mpdcc_pkg::reg_idx_t idx;
    logic                wr_en;

    assign idx    = mpdcc_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg                      <= '0;
            cfg_reg.running_ratio        <= mpdcc_pkg::RUNNING_RATIO_RST;
        end else if (wr_en) begin
            unique case (idx)
                mpdcc_pkg::REG_POSITION_GAIN: begin
                    cfg_reg.position_gain <= pwdata[15:0];
                end
                mpdcc_pkg::REG_DAMPING_GAIN: begin
                    cfg_reg.damping_gain <= pwdata[15:0];
                end
                mpdcc_pkg::REG_FEEDFORWARD_CURRENT: begin
                    cfg_reg.feedforward_current <= pwdata[14:0];
                end
                mpdcc_pkg::REG_RUNNING_RATIO: begin
                    cfg_reg.running_ratio <= pwdata[8:0];
                end
                mpdcc_pkg::REG_BREAKAWAY_ENTER_RPM: begin
                    cfg_reg.breakaway_enter_rpm <= pwdata[14:0];
                end
                mpdcc_pkg::REG_BREAKAWAY_EXIT_RPM: begin
                    cfg_reg.breakaway_exit_rpm <= pwdata[14:0];
                end
                mpdcc_pkg::REG_ACTIVE_RPM_THRESHOLD: begin
                    cfg_reg.active_rpm_threshold <= pwdata[14:0];
                end
                mpdcc_pkg::REG_POSITION_ERROR_LIMIT: begin
                    cfg_reg.position_error_limit <= pwdata[19:0];
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            mpdcc_pkg::REG_POSITION_GAIN:        prdata = 32'(cfg_reg.position_gain);
            mpdcc_pkg::REG_DAMPING_GAIN:         prdata = 32'(cfg_reg.damping_gain);
            mpdcc_pkg::REG_FEEDFORWARD_CURRENT:  prdata = 32'(cfg_reg.feedforward_current);
            mpdcc_pkg::REG_RUNNING_RATIO:        prdata = 32'(cfg_reg.running_ratio);
            mpdcc_pkg::REG_BREAKAWAY_ENTER_RPM:  prdata = 32'(cfg_reg.breakaway_enter_rpm);
            mpdcc_pkg::REG_BREAKAWAY_EXIT_RPM:   prdata = 32'(cfg_reg.breakaway_exit_rpm);
            mpdcc_pkg::REG_ACTIVE_RPM_THRESHOLD: prdata = 32'(cfg_reg.active_rpm_threshold);
            mpdcc_pkg::REG_POSITION_ERROR_LIMIT: prdata = 32'(cfg_reg.position_error_limit);
        endcase
    end

endmodule

// ----- dv/tb_motor_pd_current_control_ff.sv -----
// testbench for motor_pd_current_control_ff: random and directed control ticks checked against a predictor
`timescale 1ns / 100ps

module tb_motor_pd_current_control_ff;
    import mpdcc_pkg::*;

    localparam int  OUT_LIMIT    = 16384;
    localparam int  BRK_LIMIT    = 8192;
    localparam int  BRK_DONE_RPM = 16;
    localparam int  PERIOD_US    = 1000;
    localparam int  TAIL_CYCLES  = 10;
    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  PHASE_ITEMS  = 70;

    typedef struct {
        logic signed [15:0] target_rpm;
        logic signed [15:0] measured_rpm;
        logic signed [31:0] measured_position;
        logic               speed_link_online;
        logic               position_link_online;
    } tick_t;

    typedef struct {
        logic signed [15:0] drive_current;
        path_t              control_path;
        logic signed [20:0] position_error_used;
    } ctl_out_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [71:0]           s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [39:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state and register copy
    cfg_t        cfg_m;
    logic [47:0] setpoint_m;
    logic        breakaway_m;
    tsign_t      tsign_m;

    ctl_out_t expected_q[$];
    ctl_out_t want;
    int       n_fail = 0;
    int       cycle_count = 0;
    int       burst_left = 0;
    int       rx_run = 0;
    bit       tx_gaps = 1'b0;
    bit       rx_stalls = 1'b0;
    bit       track_dir = 1'b1;

    motor_pd_current_control_ff #(
        .OUTPUT_LIMIT      (OUT_LIMIT),
        .BRAKE_LIMIT       (BRK_LIMIT),
        .BRAKE_DONE_RPM    (BRK_DONE_RPM),
        .CONTROL_PERIOD_US (PERIOD_US)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        cfg_m = '0;
        cfg_m.running_ratio = RUNNING_RATIO_RST;
        setpoint_m = '0;
        breakaway_m = 1'b1;
        tsign_m = SIGN_ZERO;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[motor_pd_current_control_ff] ERROR");
            $finish;
        end
    end

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // one control tick of the current loop; updates the setpoint, breakaway and target sign state
    function automatic ctl_out_t control_tick(tick_t t);
        ctl_out_t    r;
        longint      tgt, mrpm, abs_t, abs_m, cur, err, num, mag, stp, e, lim, ffq8, sum;
        logic [47:0] pos_fx, dlt;
        tsign_t      sg;
        tgt = t.target_rpm;
        mrpm = t.measured_rpm;
        abs_t = tgt < 0 ? -tgt : tgt;
        abs_m = mrpm < 0 ? -mrpm : mrpm;
        pos_fx = {t.measured_position, 16'h0};
        cur = 0;
        err = 0;
        if (!t.speed_link_online) begin
            setpoint_m = pos_fx;
            breakaway_m = 1'b1;
            tsign_m = SIGN_ZERO;
            r.control_path = PATH_OFFLINE;
        end else if (abs_t <= longint'(cfg_m.active_rpm_threshold)) begin
            setpoint_m = pos_fx;
            breakaway_m = 1'b1;
            tsign_m = SIGN_ZERO;
            if (abs_m <= BRK_DONE_RPM) begin
                r.control_path = PATH_BRAKE_DONE;
            end else begin
                cur = clamp_sym((longint'(cfg_m.damping_gain) * -mrpm) / 256, BRK_LIMIT);
                r.control_path = PATH_BRAKING;
            end
        end else begin
            // setpoint advance in 1/64 degree with 16 fraction bits, rounded half away
            num = tgt * 384 * PERIOD_US * 65536;
            mag = num < 0 ? -num : num;
            stp = (mag + 500000) / 1000000;
            if (num < 0) stp = -stp;
            setpoint_m = setpoint_m + stp[47:0];
            if (!t.position_link_online) begin
                setpoint_m = pos_fx;
            end else begin
                dlt = setpoint_m - pos_fx;
                e = longint'(signed'(dlt));
                lim = longint'(cfg_m.position_error_limit) * 65536;
                e = clamp_sym(e, lim);
                setpoint_m = pos_fx + e[47:0];
                err = (e < 0 ? -e : e) >> 16;
                if (e < 0) err = -err;
            end
            sg = tgt > 0 ? SIGN_POS : SIGN_NEG;
            if (sg != tsign_m) begin
                breakaway_m = 1'b1;
                tsign_m = sg;
            end
            // enter test first, so it wins when enter is above exit
            if (abs_m <= longint'(cfg_m.breakaway_enter_rpm)) breakaway_m = 1'b1;
            else if (abs_m >= longint'(cfg_m.breakaway_exit_rpm)) breakaway_m = 1'b0;
            ffq8 = breakaway_m ? longint'(cfg_m.feedforward_current) * 256
                               : longint'(cfg_m.feedforward_current)
                                 * longint'(cfg_m.running_ratio);
            sum = longint'(cfg_m.position_gain) * err
                + longint'(cfg_m.damping_gain) * (tgt - mrpm)
                + (sg == SIGN_POS ? ffq8 : -ffq8);
            cur = clamp_sym(sum / 256, OUT_LIMIT);
            r.control_path = PATH_TRACKING;
        end
        r.drive_current = cur[15:0];
        r.position_error_used = err[20:0];
        return r;
    endfunction

    // result checker and receiver stall pattern
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_q.size() == 0) begin
                $error("result transfer with nothing expected: tdata %h tuser %0d",
                       m_tdata, m_tuser);
                n_fail++;
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[15:0] !== want.drive_current) begin
                    $error("drive_current expected %0d actual %0d",
                           want.drive_current, $signed(m_tdata[15:0]));
                    n_fail++;
                end
                if (m_tuser !== want.control_path) begin
                    $error("control_path expected %0d actual %0d", want.control_path, m_tuser);
                    n_fail++;
                end
                if (m_tdata[36:16] !== want.position_error_used) begin
                    $error("position_error_used expected %0d actual %0d",
                           want.position_error_used, $signed(m_tdata[36:16]));
                    n_fail++;
                end
            end
        end
        if (!rx_stalls) begin
            m_tready <= 1'b1;
        end else if (rx_run == 0) begin
            m_tready <= ($urandom_range(0, 2) != 0);
            rx_run = $urandom_range(1, 10);
        end else begin
            rx_run--;
        end
    end

    task automatic send_tick(tick_t t);
        s_tdata <= {6'b0, t.position_link_online, t.speed_link_online,
                    t.measured_position, t.measured_rpm, t.target_rpm};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        expected_q.push_back(control_tick(t));
        if (tx_gaps) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    // hold the sender until every expected result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // register write followed by a read back of the same register
    task automatic cfg_write(reg_idx_t idx, logic [31:0] value);
        logic [31:0] stored;
        case (idx)
            REG_POSITION_GAIN: begin
                stored = value & 32'h0000_ffff;
                cfg_m.position_gain = stored[15:0];
            end
            REG_DAMPING_GAIN: begin
                stored = value & 32'h0000_ffff;
                cfg_m.damping_gain = stored[15:0];
            end
            REG_FEEDFORWARD_CURRENT: begin
                stored = value & 32'h0000_7fff;
                cfg_m.feedforward_current = stored[14:0];
            end
            REG_RUNNING_RATIO: begin
                stored = value & 32'h0000_01ff;
                cfg_m.running_ratio = stored[8:0];
            end
            REG_BREAKAWAY_ENTER_RPM: begin
                stored = value & 32'h0000_7fff;
                cfg_m.breakaway_enter_rpm = stored[14:0];
            end
            REG_BREAKAWAY_EXIT_RPM: begin
                stored = value & 32'h0000_7fff;
                cfg_m.breakaway_exit_rpm = stored[14:0];
            end
            REG_ACTIVE_RPM_THRESHOLD: begin
                stored = value & 32'h0000_7fff;
                cfg_m.active_rpm_threshold = stored[14:0];
            end
            default: begin
                stored = value & 32'h000f_ffff;
                cfg_m.position_error_limit = stored[19:0];
            end
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (pready !== 1'b1) @(posedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (pready !== 1'b1) @(posedge aclk);
        if (prdata !== stored) begin
            $error("register %s expected %0d actual %0d", idx.name(), stored, prdata);
            n_fail++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_cfg(cfg_t c);
        cfg_write(REG_POSITION_GAIN, 32'(c.position_gain));
        cfg_write(REG_DAMPING_GAIN, 32'(c.damping_gain));
        cfg_write(REG_FEEDFORWARD_CURRENT, 32'(c.feedforward_current));
        cfg_write(REG_RUNNING_RATIO, 32'(c.running_ratio));
        cfg_write(REG_BREAKAWAY_ENTER_RPM, 32'(c.breakaway_enter_rpm));
        cfg_write(REG_BREAKAWAY_EXIT_RPM, 32'(c.breakaway_exit_rpm));
        cfg_write(REG_ACTIVE_RPM_THRESHOLD, 32'(c.active_rpm_threshold));
        cfg_write(REG_POSITION_ERROR_LIMIT, 32'(c.position_error_limit));
    endtask

    function automatic cfg_t rand_cfg();
        cfg_t c;
        c.position_gain = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 600));
        c.damping_gain = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 2000));
        c.feedforward_current = 15'($urandom_range(0, 16384));
        c.running_ratio = 9'($urandom_range(0, 256));
        c.breakaway_enter_rpm = 15'($urandom_range(0, 400));
        c.breakaway_exit_rpm = c.breakaway_enter_rpm + 15'($urandom_range(0, 600));
        c.active_rpm_threshold = ($urandom_range(0, 3) == 0) ? 15'd0
                                                              : 15'($urandom_range(0, 1500));
        c.position_error_limit = ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                                              : 20'($urandom_range(0, 5000));
        return c;
    endfunction

    function automatic tick_t make_tick(int tgt, int meas, logic [31:0] pos, bit sok, bit pok);
        tick_t t;
        t.target_rpm = 16'(tgt);
        t.measured_rpm = 16'(meas);
        t.measured_position = pos;
        t.speed_link_online = sok;
        t.position_link_online = pok;
        return t;
    endfunction

    // mostly well-formed ticks around the current setpoint, some braking runs, some noise
    function automatic tick_t gen_tick();
        tick_t t;
        int    kind, mag, span;
        kind = $urandom_range(0, 99);
        t.target_rpm = 16'($urandom);
        t.measured_rpm = 16'($urandom);
        t.measured_position = $urandom;
        t.speed_link_online = ($urandom_range(0, 15) != 0);
        t.position_link_online = ($urandom_range(0, 9) != 0);
        if (kind < 15) begin
            t.speed_link_online = 1'($urandom);
            t.position_link_online = 1'($urandom);
        end else if (kind < 30) begin
            mag = $urandom_range(0, cfg_m.active_rpm_threshold);
            t.target_rpm = $urandom_range(0, 1) ? 16'(mag) : 16'(-mag);
            t.measured_rpm = $urandom_range(0, 1) ? 16'(int'($urandom_range(0, 64)) - 32)
                                                  : 16'(int'($urandom_range(0, 4000)) - 2000);
        end else begin
            if ($urandom_range(0, 11) == 0) track_dir = !track_dir;
            mag = int'(cfg_m.active_rpm_threshold) + 1 + int'($urandom_range(0, 2500));
            if (mag > 32767) t.target_rpm = 16'h8000;
            else t.target_rpm = track_dir ? 16'(mag) : 16'(-mag);
            // speeds around the breakaway hysteresis band
            mag = int'($urandom_range(0, int'(cfg_m.breakaway_exit_rpm)
                                         + int'(cfg_m.breakaway_enter_rpm) + 100));
            t.measured_rpm = (t.target_rpm[15] ^ ($urandom_range(0, 6) == 0)) ? 16'(-mag)
                                                                              : 16'(mag);
            span = 2 * int'(cfg_m.position_error_limit) + 8;
            t.measured_position = setpoint_m[47:16]
                                + 32'(int'($urandom_range(0, 2 * span)) - span);
        end
        return t;
    endfunction

    task automatic run_phase(int n_items);
        repeat (n_items) begin
            send_tick(gen_tick());
            if ($urandom_range(0, 59) == 0) drain();
        end
        drain();
    endtask

    task automatic test_reset_defaults();
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        run_phase(30);
    endtask

    task automatic test_directed_paths();
        cfg_t c;
        c.position_gain = 16'd256;
        c.damping_gain = 16'd512;
        c.feedforward_current = 15'd1000;
        c.running_ratio = 9'd128;
        c.breakaway_enter_rpm = 15'd50;
        c.breakaway_exit_rpm = 15'd200;
        c.active_rpm_threshold = 15'd100;
        c.position_error_limit = 20'd1000;
        load_cfg(c);
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        // offline reset with extreme fields
        send_tick(make_tick(-32768, 32767, 32'h7fff_ffff, 1'b0, 1'b1));
        send_tick(make_tick(32767, -32768, 32'h8000_0000, 1'b0, 1'b0));
        // brake done at the band edge, braking just outside, brake clamp both ways
        send_tick(make_tick(0, 16, 32'd0, 1'b1, 1'b1));
        send_tick(make_tick(100, -16, 32'd0, 1'b1, 1'b1));
        send_tick(make_tick(-100, 17, 32'd0, 1'b1, 1'b1));
        send_tick(make_tick(0, -32768, 32'd5, 1'b1, 1'b1));
        send_tick(make_tick(0, 32767, 32'd5, 1'b1, 1'b1));
        // breakaway hysteresis: enter edge, hold, exit edge, stay running
        send_tick(make_tick(101, 0, 32'd0, 1'b1, 1'b1));
        send_tick(make_tick(101, 50, 32'd0, 1'b1, 1'b1));
        send_tick(make_tick(101, 120, 32'd0, 1'b1, 1'b1));
        send_tick(make_tick(101, 200, 32'd0, 1'b1, 1'b1));
        send_tick(make_tick(101, 150, 32'd0, 1'b1, 1'b1));
        // direction change at the exit speed: the exit test still clears breakaway
        send_tick(make_tick(-101, -200, 32'd0, 1'b1, 1'b1));
        // full speed, error clamp, position link offline
        send_tick(make_tick(32767, 32767, 32'd0, 1'b1, 1'b1));
        send_tick(make_tick(32767, 0, 32'd0, 1'b1, 1'b1));
        send_tick(make_tick(32767, 0, 32'd0, 1'b1, 1'b0));
        send_tick(make_tick(-32768, -32768, 32'h7fff_ffff, 1'b1, 1'b1));
        send_tick(make_tick(-32768, 0, 32'h8000_0000, 1'b1, 1'b1));
        send_tick(make_tick(200, 300, -32'sd1000, 1'b1, 1'b1));
        drain();
    endtask

    task automatic test_register_extremes();
        cfg_t c;
        c = '0;
        load_cfg(c);
        tx_gaps = 1'b1;
        rx_stalls = 1'b0;
        run_phase(PHASE_ITEMS);
        c.position_gain = 16'hffff;
        c.damping_gain = 16'hffff;
        c.feedforward_current = 15'd16384;
        c.running_ratio = 9'd256;
        c.breakaway_enter_rpm = 15'd32767;
        c.breakaway_exit_rpm = 15'd32767;
        c.active_rpm_threshold = 15'd32767;
        c.position_error_limit = 20'hfffff;
        load_cfg(c);
        tx_gaps = 1'b0;
        rx_stalls = 1'b1;
        run_phase(PHASE_ITEMS);
    endtask

    task automatic test_register_oddities();
        cfg_t c;
        // ratio above unity and enter above exit
        c = rand_cfg();
        c.running_ratio = 9'd511;
        c.breakaway_enter_rpm = 15'd300;
        c.breakaway_exit_rpm = 15'd100;
        c.active_rpm_threshold = 15'd50;
        load_cfg(c);
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        run_phase(PHASE_ITEMS);
    endtask

    task automatic test_random_mix();
        repeat (5) begin
            load_cfg(rand_cfg());
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            run_phase(PHASE_ITEMS);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_paths();
        test_register_extremes();
        test_register_oddities();
        test_random_mix();
        drain();
        if (n_fail == 0) begin
            $display("[motor_pd_current_control_ff] OK");
        end else begin
            $display("[motor_pd_current_control_ff] ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/mpdcc_pkg.sv
src/mpdcc_regs.sv
src/motor_pd_current_control_ff.sv
dv/tb_motor_pd_current_control_ff.sv
